@@ src/bald_pkg.sv @@
`default_nettype none

package bald_pkg;

   // Storage geometry
   localparam int CAPACITY      = 256;
   localparam int ELEMENT_WIDTH = 32;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CNT_W         = $clog2(CAPACITY + 1);

   // Request codes
   localparam logic [2:0] REQ_INS_HEAD = 3'd0;
   localparam logic [2:0] REQ_INS_TAIL = 3'd1;
   localparam logic [2:0] REQ_REM_HEAD = 3'd2;
   localparam logic [2:0] REQ_REM_TAIL = 3'd3;
   localparam logic [2:0] REQ_RD_HEAD  = 3'd4;
   localparam logic [2:0] REQ_RD_TAIL  = 3'd5;
   localparam logic [2:0] REQ_RD_INDEX = 3'd6;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_RANGE = 2'd3;

   // Movement of the cell row
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_LEFT  = 2'd1,
      CELL_RIGHT = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [ELEMENT_WIDTH-1:0] word;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_FWD  = 3'b010,
      S_BACK = 3'b100
   } ctrl_state_type;

endpackage

`default_nettype wire

@@ src/bald_if.sv @@
`default_nettype none

interface bald_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] element_in;
   logic [7:0]  position;

   modport source (output valid, output req_type, output element_in, output position,
                   input ready);
   modport sink   (input valid, input req_type, input element_in, input position,
                   output ready);
endinterface

interface bald_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] element_out;
   logic [8:0]  list_size;
   logic [1:0]  status;

   modport source (output valid, output element_out, output list_size, output status,
                   input ready);
   modport sink   (input valid, input element_out, input list_size, input status,
                   output ready);
endinterface

`default_nettype wire

@@ src/bald_cell.sv @@
`default_nettype none

module bald_cell import bald_pkg::*; (
   input  wire logic                     clock,
   input  wire cell_ctl_type             ctl,
   input  wire logic                     load,
   input  wire logic [ELEMENT_WIDTH-1:0] from_left,
   input  wire logic [ELEMENT_WIDTH-1:0] from_right,
   output      logic [ELEMENT_WIDTH-1:0] data
);

   logic [ELEMENT_WIDTH-1:0] data_ff;
   logic [ELEMENT_WIDTH-1:0] data_in;

   // Take the new word, or move with the row, or hold
   always_comb begin
      priority if (load) begin
         data_in = ctl.word;
      end else begin
         unique case (ctl.op)
            CELL_LEFT:  data_in = from_right;
            CELL_RIGHT: data_in = from_left;
            default:    data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

@@ src/bald_ctrl.sv @@
`default_nettype none

module bald_ctrl import bald_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   bald_req_if.sink                      req,
   bald_rsp_if.source                    rsp,
   input  wire logic [ELEMENT_WIDTH-1:0] head_data,
   output      cell_ctl_type             cell_ctl,
   output      logic [CAPACITY-1:0]      cell_load
);

   ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] steps_ff, steps_in;
   logic [IDX_W-1:0] dist_ff, dist_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_elem_ff, rsp_elem_in;
   logic [8:0]  rsp_size_ff, rsp_size_in;
   logic [1:0]  rsp_stat_ff, rsp_stat_in;

   logic             accept;
   logic             full;
   logic             empty;
   logic             pos_big;
   logic [IDX_W-1:0] tail_pos;
   logic             load_head;
   logic             load_tail;

   // Decoded request
   cell_op_type      dec_op;
   logic             dec_load_head;
   logic             dec_load_tail;
   logic [CNT_W-1:0] dec_count;
   logic [1:0]       dec_stat;
   logic [31:0]      dec_elem;
   logic             dec_walk;
   logic [IDX_W-1:0] dec_dist;

   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign pos_big  = (32'(req.position) >= 32'(count_ff));
   assign tail_pos = IDX_W'(count_ff - CNT_W'(1));

   // Decode the request against the current size
   always_comb begin
      dec_op        = CELL_HOLD;
      dec_load_head = 1'b0;
      dec_load_tail = 1'b0;
      dec_count     = count_ff;
      dec_stat      = STAT_OK;
      dec_elem      = '0;
      dec_walk      = 1'b0;
      dec_dist      = '0;
      unique case (req.req_type)
         REQ_INS_HEAD: begin
            if (full) begin
               dec_stat = STAT_FULL;
            end else begin
               dec_op        = CELL_RIGHT;
               dec_load_head = 1'b1;
               dec_count     = count_ff + CNT_W'(1);
            end
         end
         REQ_INS_TAIL: begin
            if (full) begin
               dec_stat = STAT_FULL;
            end else begin
               dec_load_tail = 1'b1;
               dec_count     = count_ff + CNT_W'(1);
            end
         end
         REQ_REM_HEAD: begin
            if (empty) begin
               dec_stat = STAT_EMPTY;
            end else begin
               dec_op    = CELL_LEFT;
               dec_count = count_ff - CNT_W'(1);
            end
         end
         REQ_REM_TAIL: begin
            if (empty) begin
               dec_stat = STAT_EMPTY;
            end else begin
               dec_count = count_ff - CNT_W'(1);
            end
         end
         REQ_RD_HEAD: begin
            if (empty) begin
               dec_stat = STAT_EMPTY;
            end else begin
               dec_elem = 32'(head_data);
            end
         end
         REQ_RD_TAIL: begin
            if (empty) begin
               dec_stat = STAT_EMPTY;
            end else if (tail_pos == '0) begin
               dec_elem = 32'(head_data);
            end else begin
               dec_walk = 1'b1;
               dec_dist = tail_pos;
            end
         end
         REQ_RD_INDEX: begin
            if (empty) begin
               dec_stat = STAT_EMPTY;
            end else if (pos_big) begin
               dec_stat = STAT_RANGE;
            end else if (req.position == '0) begin
               dec_elem = 32'(head_data);
            end else begin
               dec_walk = 1'b1;
               dec_dist = IDX_W'(req.position);
            end
         end
         default: begin
         end
      endcase
   end

   // Sequence the row and load the response register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      dist_in       = dist_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_elem_in   = rsp_elem_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_stat_in   = rsp_stat_ff;
      cell_ctl.op   = CELL_HOLD;
      cell_ctl.word = ELEMENT_WIDTH'(req.element_in);
      load_head     = 1'b0;
      load_tail     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cell_ctl.op = dec_op;
               load_head   = dec_load_head;
               load_tail   = dec_load_tail;
               count_in    = dec_count;
               if (dec_walk) begin
                  steps_in = dec_dist;
                  dist_in  = dec_dist;
                  state_in = S_FWD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_elem_in  = dec_elem;
                  rsp_size_in  = 9'(dec_count);
                  rsp_stat_in  = dec_stat;
               end
            end
         end
         S_FWD: begin
            // Rotate the target to the head cell, then capture it
            if (steps_ff != '0) begin
               cell_ctl.op = CELL_LEFT;
               steps_in    = steps_ff - IDX_W'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_elem_in  = 32'(head_data);
               rsp_size_in  = 9'(count_ff);
               rsp_stat_in  = STAT_OK;
               steps_in     = dist_ff;
               state_in     = S_BACK;
            end
         end
         S_BACK: begin
            // Rotate the row back to its original order
            cell_ctl.op = CELL_RIGHT;
            steps_in    = steps_ff - IDX_W'(1);
            if (steps_ff == IDX_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Per-cell write enables
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_load[i] = (load_head && (i == 0)) ||
                        (load_tail && (count_ff[IDX_W-1:0] == IDX_W'(i)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_elem_ff <= rsp_elem_in;
      rsp_size_ff <= rsp_size_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.element_out = rsp_elem_ff;
   assign rsp.list_size   = rsp_size_ff;
   assign rsp.status      = rsp_stat_ff;

endmodule

`default_nettype wire

@@ src/bounded_array_list_deque.sv @@
`default_nettype none

// Bounded deque of CAPACITY element words, kept in a row of cells that forms
// a ring: the head element sits in cell 0 whenever the block is idle. Insert
// head, insert tail, remove head, remove tail and read head are done as the
// request is taken, since the whole row shifts by one cell at once; so are
// read index at position 0, read tail on a one-element list and every request
// that ends in an error. A read at index p > 0 (read tail uses p = size - 1)
// rotates the ring p cells left to bring the element to cell 0, captures it,
// and rotates p cells back. A new request is taken once no rotation is running
// and the previous response has left or is leaving the output register. No
// clearing pass follows reset; the size is 0.

module bounded_array_list_deque import bald_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   bald_req_if.sink   req_ch,
   bald_rsp_if.source rsp_ch
);

   cell_ctl_type             cell_ctl;
   logic [CAPACITY-1:0]      cell_load;
   logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];

   bald_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .head_data (cell_data[0]),
      .cell_ctl  (cell_ctl),
      .cell_load (cell_load)
   );

   // Ring of cells: each one talks only to its two neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      bald_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .load       (cell_load[i]),
         .from_left  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
         .from_right (cell_data[(i + 1) % CAPACITY]),
         .data       (cell_data[i])
      );
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_bounded_array_list_deque.sv @@
`default_nettype none

module tb_bounded_array_list_deque;
   import bald_pkg::*;

   // Code outside the defined request set; the block must leave the list unchanged and answer with OK status
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   // Cycles without any handshake before the run is declared hung
   localparam int HANG_LIMIT = 4000;

   // Cycles to idle after the last response, covering the longest indexed read
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

   typedef struct {
      logic [31:0]      word;
      logic [CNT_W-1:0] size;
      logic [1:0]       status;
   } deque_rsp_type;

   logic clock;
   logic reset;

   bald_req_if req_ch ();
   bald_rsp_if rsp_ch ();

   bounded_array_list_deque DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the deque contents
   logic [ELEMENT_WIDTH-1:0] shadow_store [CAPACITY];
   logic [IDX_W-1:0]         shadow_head;
   int                       shadow_count;

   deque_rsp_type pending_rsp [$];
   int            error_count;
   int            idle_cycles;
   bit            steady_flow;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [IDX_W-1:0] ring_slot(input int idx);
      return shadow_head + idx[IDX_W-1:0];
   endfunction

   // Apply one request to the shadow deque and queue the response it yields
   task automatic deque_step(input logic [2:0] kind, input logic [31:0] word,
                             input logic [7:0] pos);
      deque_rsp_type r;
      r.word   = '0;
      r.status = STAT_OK;
      case (kind)
         REQ_INS_HEAD: begin
            if (shadow_count >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               shadow_head = shadow_head - IDX_W'(1);
               shadow_store[shadow_head] = word[ELEMENT_WIDTH-1:0];
               shadow_count++;
            end
         end
         REQ_INS_TAIL: begin
            if (shadow_count >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               shadow_store[ring_slot(shadow_count)] = word[ELEMENT_WIDTH-1:0];
               shadow_count++;
            end
         end
         REQ_REM_HEAD: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               shadow_head = shadow_head + IDX_W'(1);
               shadow_count--;
            end
         end
         REQ_REM_TAIL: begin
            if (shadow_count == 0) r.status = STAT_EMPTY;
            else shadow_count--;
         end
         REQ_RD_HEAD: begin
            if (shadow_count == 0) r.status = STAT_EMPTY;
            else r.word = 32'(shadow_store[ring_slot(0)]);
         end
         REQ_RD_TAIL: begin
            if (shadow_count == 0) r.status = STAT_EMPTY;
            else r.word = 32'(shadow_store[ring_slot(shadow_count - 1)]);
         end
         REQ_RD_INDEX: begin
            if (shadow_count == 0) r.status = STAT_EMPTY;
            else if (int'(pos) >= shadow_count) r.status = STAT_RANGE;
            else r.word = 32'(shadow_store[ring_slot(int'(pos))]);
         end
         default: ;
      endcase
      r.size = CNT_W'(shadow_count);
      pending_rsp.push_back(r);
   endtask

   // Drive one request; entered and left at a falling edge
   task automatic send_request(input logic [2:0] kind, input logic [31:0] word,
                               input logic [7:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.element_in <= word;
      req_ch.position   <= pos;
      do @(posedge clock); while (!req_ch.ready);
      deque_step(kind, word, pos);
      @(negedge clock);
   endtask

   // Response ready: random stalls, none while steady flow is on
   initial begin
      int run_len;
      int stall_len;
      rsp_ch.ready <= 1'b0;
      forever begin
         run_len = $urandom_range(1, 16);
         @(negedge clock) rsp_ch.ready <= 1'b1;
         repeat (run_len - 1) @(negedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            @(negedge clock) rsp_ch.ready <= 1'b0;
            repeat (stall_len - 1) @(negedge clock);
         end
      end
   end

   // Compare each response with the oldest pending one
   always @(posedge clock) begin
      deque_rsp_type exp_rsp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response word %h size %0d status %0d", $time,
                     rsp_ch.element_out, rsp_ch.list_size, rsp_ch.status);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_ch.element_out !== exp_rsp.word) begin
               $display("%0t: element_out expected %h actual %h", $time,
                        exp_rsp.word, rsp_ch.element_out);
               error_count++;
            end
            if (rsp_ch.list_size !== exp_rsp.size) begin
               $display("%0t: list_size expected %0d actual %0d", $time,
                        exp_rsp.size, rsp_ch.list_size);
               error_count++;
            end
            if (rsp_ch.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_rsp.status, rsp_ch.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("tb_bounded_array_list_deque NOT OK");
            $finish;
         end
      end
   end

   // Removes and reads on an empty list, plus the unused code
   task automatic test_empty_list();
      send_request(REQ_REM_HEAD, $urandom, 8'd0);
      send_request(REQ_REM_TAIL, $urandom, 8'd0);
      send_request(REQ_RD_HEAD, $urandom, 8'd0);
      send_request(REQ_RD_TAIL, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd255);
      send_request(REQ_UNUSED, $urandom, 8'd255);
   endtask

   // Every operation on a short list, extreme words and out-of-range index
   task automatic test_basic_ops();
      send_request(REQ_INS_HEAD, 32'hFFFF_FFFF, 8'd0);
      send_request(REQ_INS_TAIL, 32'h0000_0000, 8'd255);
      send_request(REQ_INS_HEAD, 32'hA5A5_5A5A, 8'd0);
      send_request(REQ_RD_HEAD, $urandom, 8'd0);
      send_request(REQ_RD_TAIL, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd1);
      send_request(REQ_RD_INDEX, $urandom, 8'd2);
      send_request(REQ_RD_INDEX, $urandom, 8'd3);
      send_request(REQ_RD_INDEX, $urandom, 8'd255);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF, 8'd1);
      send_request(REQ_REM_HEAD, $urandom, 8'd0);
      send_request(REQ_RD_HEAD, $urandom, 8'd0);
      send_request(REQ_REM_TAIL, $urandom, 8'd0);
      send_request(REQ_RD_TAIL, $urandom, 8'd0);
      send_request(REQ_REM_TAIL, $urandom, 8'd0);
      send_request(REQ_REM_HEAD, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd0);
   endtask

   // Fill to capacity, hit the full cases and wrap, then drain
   task automatic test_full_list();
      logic [2:0] kind;
      while (shadow_count < CAPACITY) begin
         steady_flow = ($urandom_range(0, 31) == 0) ? ~steady_flow : steady_flow;
         kind = $urandom_range(0, 1) ? REQ_INS_HEAD : REQ_INS_TAIL;
         send_request(kind, $urandom, 8'($urandom));
      end
      steady_flow = 1'b0;
      send_request(REQ_INS_HEAD, $urandom, 8'd0);
      send_request(REQ_INS_TAIL, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd255);
      send_request(REQ_RD_TAIL, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd128);
      // remove head at full capacity, then check the new head
      send_request(REQ_REM_HEAD, $urandom, 8'd0);
      send_request(REQ_RD_HEAD, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd255);
      send_request(REQ_INS_TAIL, $urandom, 8'd0);
      send_request(REQ_RD_TAIL, $urandom, 8'd0);
      send_request(REQ_RD_INDEX, $urandom, 8'd255);
      while (shadow_count > 0) begin
         steady_flow = ($urandom_range(0, 31) == 0) ? ~steady_flow : steady_flow;
         if ($urandom_range(0, 7) == 0)
            send_request(REQ_RD_INDEX, $urandom, 8'($urandom_range(0, shadow_count - 1)));
         else
            send_request($urandom_range(0, 1) ? REQ_REM_HEAD : REQ_REM_TAIL, $urandom, 8'd0);
      end
      steady_flow = 1'b0;
      send_request(REQ_REM_TAIL, $urandom, 8'd0);
   endtask

   // Random mix drifting toward a moving target size
   task automatic test_random_mix(input int n_items);
      int         target;
      int         roll;
      bit         grow;
      logic [2:0] kind;
      logic [7:0] pos;
      target = 0;
      for (int i = 0; i < n_items; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 5))
               0: target = 0;
               1: target = 1;
               2: target = CAPACITY;
               3: target = CAPACITY - 1;
               default: target = $urandom_range(2, 64);
            endcase
            steady_flow = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         grow = (shadow_count < target);
         if (roll < 3) begin
            kind = REQ_UNUSED;
         end else if (roll < 55) begin
            // mostly move toward the target, sometimes against it
            if (roll >= 45) grow = ~grow;
            if (grow) kind = $urandom_range(0, 1) ? REQ_INS_HEAD : REQ_INS_TAIL;
            else kind = $urandom_range(0, 1) ? REQ_REM_HEAD : REQ_REM_TAIL;
         end else if (roll < 70) begin
            kind = $urandom_range(0, 1) ? REQ_RD_HEAD : REQ_RD_TAIL;
         end else begin
            kind = REQ_RD_INDEX;
         end
         if (shadow_count > 0 && $urandom_range(0, 99) < 85)
            pos = 8'($urandom_range(0, shadow_count - 1));
         else
            pos = 8'($urandom_range(0, 255));
         send_request(kind, $urandom, pos);
      end
      steady_flow = 1'b0;
   endtask

   // Reset, run the tests in turn, then drain and report
   initial begin
      error_count  = 0;
      shadow_count = 0;
      shadow_head  = '0;
      steady_flow  = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_INS_HEAD;
      req_ch.element_in <= '0;
      req_ch.position   <= '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(negedge clock);

      test_empty_list();
      test_basic_ops();
      test_full_list();
      test_random_mix(500);

      req_ch.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("tb_bounded_array_list_deque OK");
      end else begin
         $display("tb_bounded_array_list_deque NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
